// File: rtl/core/idtfp_pkg.sv
// Shared types, event codes and helpers for the ID3v2 tag frame parser.
`default_nettype none

package idtfp_pkg;

	// Tag and frame headers are both ten bytes long
	localparam int unsigned HEADER_BYTES = 10;
	localparam logic [3:0]  LAST_FIELD   = 4'(HEADER_BYTES - 1);

	// Default depth of the result queue
	localparam int unsigned RES_DEPTH_DEF = 4;

	// Event codes
	localparam logic [2:0] EV_TAG_OK     = 3'd0;
	localparam logic [2:0] EV_TAG_REJECT = 3'd1;
	localparam logic [2:0] EV_FRAME_HDR  = 3'd2;
	localparam logic [2:0] EV_FRAME_DATA = 3'd3;
	localparam logic [2:0] EV_TAG_DONE   = 3'd4;
	localparam logic [2:0] EV_FRAME_ERR  = 3'd5;

	// Reject reasons
	localparam logic REJ_BAD_ID  = 1'b0;
	localparam logic REJ_TOO_BIG = 1'b1;

	// "ID3" identifier: first two bytes, then the third
	localparam logic [15:0] ID_HEAD = 16'h4944;
	localparam logic [7:0]  ID_TAIL = 8'h33;

	// Synchsafe frame sizes from this major version on
	localparam logic [7:0] SYNCHSAFE_MAJOR = 8'd4;

	// One result item
	typedef struct packed {
		logic [2:0]  event_res;
		logic        reject_reason;
		logic [7:0]  ver_major;
		logic [7:0]  ver_rev;
		logic [27:0] tag_size;
		logic [31:0] frm_id;
		logic [15:0] frm_flags;
		logic [31:0] frm_size;
		logic [7:0]  data_byte;
		logic        last_of_frame;
		logic        run_last;
	} res_t;

	// Up to two results caused by one byte
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} step_out_t;

	// Drop bit 7 of each of four bytes
	function automatic logic [27:0] synchsafe(input logic [31:0] v);
		return {v[30:24], v[22:16], v[14:8], v[6:0]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/idtfp_if.sv
// Request channel interfaces: file bytes in, parser events out.
`default_nettype none

interface idtfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       first;

	modport source (output valid, byte_value, first, input ready);
	modport sink   (input valid, byte_value, first, output ready);
endinterface

interface idtfp_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic        reject_reason;
	logic [7:0]  ver_major;
	logic [7:0]  ver_rev;
	logic [27:0] tag_size;
	logic [31:0] frm_id;
	logic [15:0] frm_flags;
	logic [31:0] frm_size;
	logic [7:0]  data_byte;
	logic        last_of_frame;
	logic        run_last;

	modport source (output valid, event_res, reject_reason, ver_major, ver_rev,
		tag_size, frm_id, frm_flags, frm_size, data_byte, last_of_frame, run_last,
		input ready);
	modport sink (input valid, event_res, reject_reason, ver_major, ver_rev,
		tag_size, frm_id, frm_flags, frm_size, data_byte, last_of_frame, run_last,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/idtfp_step.sv
// Parser state and the per-byte decode: tag header, frame headers, frame data.
`default_nettype none

module idtfp_step
	import idtfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [7:0]  byte_value,
	input  wire logic        first,
	input  wire logic [31:0] stream_length,
	output step_out_t        step_out
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_HDR   = 3'd1;
	localparam logic [2:0] PH_FHDR  = 3'd2;
	localparam logic [2:0] PH_FDATA = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  fcnt_q, fcnt_d;
	logic [63:0] hshift_q, hshift_d;
	logic [15:0] fshift_q, fshift_d;
	logic [27:0] tag_rem_q, tag_rem_d;
	logic [31:0] frame_rem_q, frame_rem_d;
	logic [7:0]  major_q, major_d;
	logic [7:0]  rev_q, rev_d;

	// state seen by this byte (a first byte restarts the header)
	logic [2:0]  ph;
	logic [3:0]  fc;
	logic [63:0] hs;
	logic [15:0] fs;

	// header completion values
	logic [63:0] hs_full;
	logic [15:0] fs_full;
	logic [27:0] tsize;
	logic [31:0] fsize;
	logic        id_ok;
	logic        too_big;
	logic [27:0] tr_dec;
	logic [31:0] fr_dec;

	res_t       r0, r1;
	logic [1:0] num;

	always_comb begin
		ph = first ? PH_HDR : phase_q;
		fc = first ? 4'd0 : fcnt_q;
		hs = first ? 64'd0 : hshift_q;
		fs = first ? 16'd0 : fshift_q;

		hs_full = {hs[55:0], byte_value};
		fs_full = {fs[7:0], byte_value};
		tsize   = synchsafe(hs_full[31:0]);
		id_ok   = (fs == ID_HEAD) && (hs_full[63:56] == ID_TAIL);
		too_big = ({5'd0, tsize} + 33'(HEADER_BYTES)) > {1'b0, stream_length};
		fsize   = (major_q >= SYNCHSAFE_MAJOR) ? {4'd0, synchsafe(hs[31:0])} : hs[31:0];
		tr_dec  = tag_rem_q - 28'd1;
		fr_dec  = frame_rem_q - 32'd1;

		phase_d     = ph;
		fcnt_d      = fc;
		hshift_d    = hs;
		fshift_d    = fs;
		tag_rem_d   = tag_rem_q;
		frame_rem_d = frame_rem_q;
		major_d     = major_q;
		rev_d       = rev_q;
		r0          = '0;
		r1          = '0;
		num         = 2'd0;

		unique case (ph)
			// tag header: two identifier bytes, then eight more
			PH_HDR: begin
				if (fc < 4'd2) begin
					fshift_d = fs_full;
				end else begin
					hshift_d = hs_full;
				end
				fcnt_d = fc + 4'd1;
				if (fc == LAST_FIELD) begin
					major_d      = hs_full[55:48];
					rev_d        = hs_full[47:40];
					r0.ver_major = hs_full[55:48];
					r0.ver_rev   = hs_full[47:40];
					r0.tag_size  = tsize;
					fcnt_d       = 4'd0;
					hshift_d     = '0;
					fshift_d     = '0;
					num          = 2'd1;
					if (!id_ok || too_big) begin
						r0.event_res     = EV_TAG_REJECT;
						r0.reject_reason = id_ok ? REJ_TOO_BIG : REJ_BAD_ID;
						phase_d          = PH_DONE;
					end else begin
						r0.event_res = EV_TAG_OK;
						tag_rem_d    = tsize;
						if (tsize == 28'd0) begin
							r1.event_res = EV_TAG_DONE;
							num          = 2'd2;
							phase_d      = PH_DONE;
						end else begin
							phase_d = PH_FHDR;
						end
					end
				end
			end
			// frame header: padding and short-body checks on its first byte
			PH_FHDR: begin
				if (fc == 4'd0 && byte_value == 8'd0) begin
					r0.event_res = EV_TAG_DONE;
					num          = 2'd1;
					phase_d      = PH_DONE;
				end else if (fc == 4'd0 && tag_rem_q < 28'(HEADER_BYTES)) begin
					r0.event_res = EV_FRAME_ERR;
					num          = 2'd1;
					phase_d      = PH_DONE;
				end else begin
					if (fc < 4'd8) begin
						hshift_d = hs_full;
					end else begin
						fshift_d = fs_full;
					end
					tag_rem_d = tr_dec;
					fcnt_d    = fc + 4'd1;
					if (fc == LAST_FIELD) begin
						fcnt_d   = 4'd0;
						hshift_d = '0;
						fshift_d = '0;
						num      = 2'd1;
						if (fsize > {4'd0, tr_dec}) begin
							r0.event_res = EV_FRAME_ERR;
							phase_d      = PH_DONE;
						end else begin
							r0.event_res = EV_FRAME_HDR;
							r0.frm_id    = hs[63:32];
							r0.frm_flags = fs_full;
							r0.frm_size  = fsize;
							if (fsize == 32'd0) begin
								if (tr_dec == 28'd0) begin
									r1.event_res = EV_TAG_DONE;
									num          = 2'd2;
									phase_d      = PH_DONE;
								end
							end else begin
								frame_rem_d = fsize;
								phase_d     = PH_FDATA;
							end
						end
					end
				end
			end
			// frame data passes through
			PH_FDATA: begin
				frame_rem_d      = fr_dec;
				tag_rem_d        = tr_dec;
				r0.event_res     = EV_FRAME_DATA;
				r0.data_byte     = byte_value;
				r0.last_of_frame = (fr_dec == 32'd0);
				num              = 2'd1;
				if (fr_dec == 32'd0) begin
					if (tr_dec == 28'd0) begin
						r1.event_res = EV_TAG_DONE;
						num          = 2'd2;
						phase_d      = PH_DONE;
					end else begin
						phase_d = PH_FHDR;
					end
				end
			end
			default: begin
			end
		endcase

		// mark the last result of this byte
		if (num == 2'd1) begin
			r0.run_last = 1'b1;
		end
		if (num == 2'd2) begin
			r1.run_last = 1'b1;
		end

		step_out.num = num;
		step_out.r0  = r0;
		step_out.r1  = r1;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			fcnt_q      <= '0;
			hshift_q    <= '0;
			fshift_q    <= '0;
			tag_rem_q   <= '0;
			frame_rem_q <= '0;
			major_q     <= '0;
			rev_q       <= '0;
		end else if (go) begin
			phase_q     <= phase_d;
			fcnt_q      <= fcnt_d;
			hshift_q    <= hshift_d;
			fshift_q    <= fshift_d;
			tag_rem_q   <= tag_rem_d;
			frame_rem_q <= frame_rem_d;
			major_q     <= major_d;
			rev_q       <= rev_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/idtfp_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle.
`default_nettype none

module idtfp_res_fifo
	import idtfp_pkg::*;
#(
	parameter int unsigned DEPTH = RES_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire step_out_t                push_data,
	input  wire logic                     pop,
	output res_t                          head,
	output logic [$clog2(DEPTH + 1)-1:0] count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp_1;
	logic [CW-1:0] cnt_q;
	logic [1:0]    push_n;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_n = push ? push_data.num : 2'd0;
	assign wp_1   = nxt(wp_q);
	assign head   = mem_q[rp_q];
	assign count  = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push_data.r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_1] <= push_data.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wp_q <= wp_1;
			end else if (push_n == 2'd2) begin
				wp_q <= nxt(wp_1);
			end
			if (pop) begin
				rp_q <= nxt(rp_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/id3v2_tag_frame_parser.sv
// Top level of the ID3v2 tag frame parser.
//
// A file streams in on "stream", one byte per request; "first" marks the first
// byte of a new file and restarts the parser on it. Each byte causes zero, one
// or two event requests on "events": tag header accepted or rejected, frame
// header, frame data byte, tag done, frame error. run_last marks the last event
// caused by a byte. stream_length is written through stream_length_we/_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce; reset sets it to all ones. A byte taken is held in the input
// register, then decoded and queued, and its first event is then valid on the
// event channel. Throughput: one byte per cycle while the receiver keeps up;
// a byte that causes two events queues both. The input register moves on while
// the result queue has room for two events, so a stalled receiver backs up
// through the queue, then drops "ready" on the byte channel; nothing is lost.
// Reset clears the parser to waiting for a first byte and empties the queue.
`default_nettype none

module id3v2_tag_frame_parser
	import idtfp_pkg::*;
#(
	parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	idtfp_byte_if.sink       stream,
	idtfp_event_if.source    events,
	input  wire logic        stream_length_we,
	input  wire logic [31:0] stream_length_wdata
);

	localparam int unsigned CW = $clog2(RES_DEPTH + 1);

	logic          s1_valid_q;
	logic [7:0]    byte_s1;
	logic          first_s1;
	logic [31:0]   stream_len_q;
	logic          go;
	logic          pop;
	logic [CW-1:0] cnt;
	step_out_t     step_out;
	res_t          head;

	// the input register advances when the queue can take two results
	assign go           = s1_valid_q && (cnt <= CW'(RES_DEPTH - 2));
	assign stream.ready = !s1_valid_q || go;
	assign pop          = events.valid && events.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (stream.ready) begin
			s1_valid_q <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1  <= stream.byte_value;
			first_s1 <= stream.first;
		end
	end

	// stream length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_len_q <= '1;
		end else if (stream_length_we) begin
			stream_len_q <= stream_length_wdata;
		end
	end

	idtfp_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.byte_value    (byte_s1),
		.first         (first_s1),
		.stream_length (stream_len_q),
		.step_out      (step_out)
	);

	idtfp_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.push_data (step_out),
		.pop       (pop),
		.head      (head),
		.count     (cnt)
	);

	// event channel
	assign events.valid         = (cnt != '0);
	assign events.event_res     = head.event_res;
	assign events.reject_reason = head.reject_reason;
	assign events.ver_major     = head.ver_major;
	assign events.ver_rev       = head.ver_rev;
	assign events.tag_size      = head.tag_size;
	assign events.frm_id        = head.frm_id;
	assign events.frm_flags     = head.frm_flags;
	assign events.frm_size      = head.frm_size;
	assign events.data_byte     = head.data_byte;
	assign events.last_of_frame = head.last_of_frame;
	assign events.run_last      = head.run_last;

	// queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(RES_DEPTH))
		else $error("result queue overflow");

	// second result of a byte is queued with the first, so it follows at once
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !events.run_last |=> events.valid)
		else $error("event run broken");

	// a two-result byte marks only its second result as last
	a_run_mark: assert property (@(posedge clk) disable iff (!arst_n)
		go && step_out.num == 2'd2 |-> !step_out.r0.run_last && step_out.r1.run_last)
		else $error("run_last misplaced");

	// no results while the input register is empty
	a_no_idle_push: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |=> cnt <= $past(cnt))
		else $error("result pushed without a byte");

endmodule

`default_nettype wire
